// ----- rtl/crchk_pkg.sv -----
`timescale 1ns / 1ps

package crchk_pkg;

    // field widths fixed by the interface
    localparam int CHANNEL_W  = 18;
    localparam int HEIGHT_W   = 16;
    localparam int RESULT_W   = 17;
    localparam int CONTRAST_W = 17;
    localparam int CFG_IDX_W  = 2;

    // Q16 luminance weights, sum is exactly 65536
    localparam int WEIGHT_W = 16;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RED   = 16'd13933;
    localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = 16'd46871;
    localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE  = 16'd4732;

    // 0.05 in Q16
    localparam logic [63:0] OFFSET_Q16 = 64'd3277;

    // register reset values
    localparam logic [HEIGHT_W-1:0]   RST_LARGE_HEIGHT      = 16'd384;
    localparam logic [HEIGHT_W-1:0]   RST_LARGE_BOLD_HEIGHT = 16'd299;
    localparam logic [CONTRAST_W-1:0] RST_LARGE_CONTRAST    = 17'd12288;
    localparam logic [CONTRAST_W-1:0] RST_NORMAL_CONTRAST   = 17'd18432;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LARGE_HEIGHT      = 2'd0,
        REG_LARGE_BOLD_HEIGHT = 2'd1,
        REG_LARGE_CONTRAST    = 2'd2,
        REG_NORMAL_CONTRAST   = 2'd3
    } cfg_reg_t;

endpackage

// ----- rtl/contrast_ratio_checker_core.sv -----
`timescale 1ns / 1ps

// Channel   Signals                                        Handshake
// -------   --------------------------------------------   ---------------------------
// request   fg_/bg_ red/green/blue, text_height, is_bold   start & !busy
// result    fg_/bg_luminance, contrast_ratio,              done, one cycle, no stall
//           large_text, required_contrast
// config    cfg_index, cfg_data                            cfg_valid & cfg_ready
//
// One request per clock while busy is low. The pipeline stages, in order:
// clamp, multiply, sum, min/max plus offset, then one restoring-divide stage per
// quotient bit (RATIO_FRACTION_BITS + 5 stages), whose compare-subtract sets the clock.
// busy is high during reset and drops at the clock after reset is released, then stays low.
// The result side cannot stall, so the pipeline never holds.
module contrast_ratio_checker_core #(
    parameter int CHANNEL_FRACTION_BITS = 16,
    parameter int RATIO_FRACTION_BITS   = 12
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    output logic                                       busy,
    input  logic signed [crchk_pkg::CHANNEL_W-1:0]     fg_red,
    input  logic signed [crchk_pkg::CHANNEL_W-1:0]     fg_green,
    input  logic signed [crchk_pkg::CHANNEL_W-1:0]     fg_blue,
    input  logic signed [crchk_pkg::CHANNEL_W-1:0]     bg_red,
    input  logic signed [crchk_pkg::CHANNEL_W-1:0]     bg_green,
    input  logic signed [crchk_pkg::CHANNEL_W-1:0]     bg_blue,
    input  logic        [crchk_pkg::HEIGHT_W-1:0]      text_height,
    input  logic                                       is_bold,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic        [crchk_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic        [crchk_pkg::CONTRAST_W-1:0]    cfg_data,
    output logic                                       done,
    output logic        [crchk_pkg::RESULT_W-1:0]      fg_luminance,
    output logic        [crchk_pkg::RESULT_W-1:0]      bg_luminance,
    output logic        [crchk_pkg::CONTRAST_W-1:0]    contrast_ratio,
    output logic                                       large_text,
    output logic        [crchk_pkg::CONTRAST_W-1:0]    required_contrast
);

    localparam int CFB   = CHANNEL_FRACTION_BITS;
    localparam int RFB   = RATIO_FRACTION_BITS;
    localparam int CW    = CFB + 1;                       // clamped channel, 0..1.0
    localparam int XW    = (CW > crchk_pkg::CHANNEL_W) ? CW : crchk_pkg::CHANNEL_W;
    localparam int PW    = CW + crchk_pkg::WEIGHT_W;      // weighted channel
    localparam int SW    = PW + 2;                        // three-term sum
    localparam int LW    = CW;                            // luminance, 0..1.0
    localparam int AW    = CFB + 1;                       // luminance plus offset
    localparam int QW    = RFB + 5;                       // ratio stays below 32
    localparam int LPW   = (LW > crchk_pkg::RESULT_W) ? LW : crchk_pkg::RESULT_W;
    localparam int QPW   = (QW > crchk_pkg::CONTRAST_W) ? QW : crchk_pkg::CONTRAST_W;
    localparam int LATENCY = QW + 4;

    localparam logic [CW-1:0] CH_ONE = {1'b1, {CFB{1'b0}}};
    localparam logic [AW-1:0] OFFSET = AW'((crchk_pkg::OFFSET_Q16 << CFB) >> 16);
    localparam logic [crchk_pkg::WEIGHT_W-1:0] WEIGHT [3] = '{
        crchk_pkg::WEIGHT_RED, crchk_pkg::WEIGHT_GREEN, crchk_pkg::WEIGHT_BLUE
    };

    function automatic logic [CW-1:0] clamp_ch(input logic signed [crchk_pkg::CHANNEL_W-1:0] raw);
        logic [XW-1:0] mag;
        mag = XW'(raw[crchk_pkg::CHANNEL_W-2:0]);
        if (raw[crchk_pkg::CHANNEL_W-1])
            return '0;
        else if (mag > XW'(CH_ONE))
            return CH_ONE;
        else
            return mag[CW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // control and configuration
    // ------------------------------------------------------------------
    logic init_reg;
    logic [crchk_pkg::HEIGHT_W-1:0]   large_height_reg;
    logic [crchk_pkg::HEIGHT_W-1:0]   large_bold_height_reg;
    logic [crchk_pkg::CONTRAST_W-1:0] large_contrast_reg;
    logic [crchk_pkg::CONTRAST_W-1:0] normal_contrast_reg;
    logic accept;

    assign busy      = init_reg;
    assign cfg_ready = ~init_reg;
    assign accept    = start & ~init_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= 1'b1;
        end
        else
        begin
            init_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            large_height_reg      <= crchk_pkg::RST_LARGE_HEIGHT;
            large_bold_height_reg <= crchk_pkg::RST_LARGE_BOLD_HEIGHT;
            large_contrast_reg    <= crchk_pkg::RST_LARGE_CONTRAST;
            normal_contrast_reg   <= crchk_pkg::RST_NORMAL_CONTRAST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (crchk_pkg::cfg_reg_t'(cfg_index))
                crchk_pkg::REG_LARGE_HEIGHT:
                    large_height_reg <= cfg_data[crchk_pkg::HEIGHT_W-1:0];
                crchk_pkg::REG_LARGE_BOLD_HEIGHT:
                    large_bold_height_reg <= cfg_data[crchk_pkg::HEIGHT_W-1:0];
                crchk_pkg::REG_LARGE_CONTRAST:
                    large_contrast_reg <= cfg_data;
                crchk_pkg::REG_NORMAL_CONTRAST:
                    normal_contrast_reg <= cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 1: clamp, large-text decision
    // ------------------------------------------------------------------
    logic                             s1_valid_reg;
    logic [CW-1:0]                    s1_fg_reg [3];
    logic [CW-1:0]                    s1_bg_reg [3];
    logic                             s1_large_reg;
    logic [crchk_pkg::CONTRAST_W-1:0] s1_req_reg;
    logic                             large_next;

    assign large_next = text_height >= (is_bold ? large_bold_height_reg : large_height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_fg_reg[0] <= clamp_ch(fg_red);
        s1_fg_reg[1] <= clamp_ch(fg_green);
        s1_fg_reg[2] <= clamp_ch(fg_blue);
        s1_bg_reg[0] <= clamp_ch(bg_red);
        s1_bg_reg[1] <= clamp_ch(bg_green);
        s1_bg_reg[2] <= clamp_ch(bg_blue);
        s1_large_reg <= large_next;
        s1_req_reg   <= large_next ? large_contrast_reg : normal_contrast_reg;
    end

    // ------------------------------------------------------------------
    // stage 2: weight each channel
    // ------------------------------------------------------------------
    logic                             s2_valid_reg;
    logic [PW-1:0]                    s2_fg_reg [3];
    logic [PW-1:0]                    s2_bg_reg [3];
    logic                             s2_large_reg;
    logic [crchk_pkg::CONTRAST_W-1:0] s2_req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_fg_reg[i] <= PW'(s1_fg_reg[i]) * PW'(WEIGHT[i]);
            s2_bg_reg[i] <= PW'(s1_bg_reg[i]) * PW'(WEIGHT[i]);
        end
        s2_large_reg <= s1_large_reg;
        s2_req_reg   <= s1_req_reg;
    end

    // ------------------------------------------------------------------
    // stage 3: luminance sums
    // ------------------------------------------------------------------
    logic                             s3_valid_reg;
    logic [LW-1:0]                    s3_fg_lum_reg;
    logic [LW-1:0]                    s3_bg_lum_reg;
    logic                             s3_large_reg;
    logic [crchk_pkg::CONTRAST_W-1:0] s3_req_reg;
    logic [SW-1:0]                    fg_sum;
    logic [SW-1:0]                    bg_sum;

    assign fg_sum = SW'(s2_fg_reg[0]) + SW'(s2_fg_reg[1]) + SW'(s2_fg_reg[2]);
    assign bg_sum = SW'(s2_bg_reg[0]) + SW'(s2_bg_reg[1]) + SW'(s2_bg_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_fg_lum_reg <= fg_sum[16 +: LW];
        s3_bg_lum_reg <= bg_sum[16 +: LW];
        s3_large_reg  <= s2_large_reg;
        s3_req_reg    <= s2_req_reg;
    end

    // ------------------------------------------------------------------
    // stage 4: order, add offset, load the divider
    // numerator = (lighter + offset) << RFB; the quotient fits QW bits,
    // so the bits above QW seed the partial remainder.
    // ------------------------------------------------------------------
    logic                             dv_valid_reg [QW+1];
    logic [AW-1:0]                    dv_rem_reg   [QW+1];
    logic [QW-1:0]                    dv_bits_reg  [QW+1];
    logic [QW-1:0]                    dv_quo_reg   [QW+1];
    logic [AW-1:0]                    dv_den_reg   [QW+1];
    logic [LW-1:0]                    dv_fg_reg    [QW+1];
    logic [LW-1:0]                    dv_bg_reg    [QW+1];
    logic                             dv_large_reg [QW+1];
    logic [crchk_pkg::CONTRAST_W-1:0] dv_req_reg   [QW+1];

    logic [AW-1:0] lighter_next;
    logic [AW-1:0] darker_next;
    logic [AW-1:0] num_hi_next;

    always_comb
    begin
        if (s3_fg_lum_reg > s3_bg_lum_reg)
        begin
            lighter_next = AW'(s3_fg_lum_reg) + OFFSET;
            darker_next  = AW'(s3_bg_lum_reg) + OFFSET;
        end
        else
        begin
            lighter_next = AW'(s3_bg_lum_reg) + OFFSET;
            darker_next  = AW'(s3_fg_lum_reg) + OFFSET;
        end
        num_hi_next = lighter_next >> 5;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else
            dv_valid_reg[0] <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        dv_rem_reg[0]   <= num_hi_next;
        dv_bits_reg[0]  <= {lighter_next[4:0], {RFB{1'b0}}};
        dv_quo_reg[0]   <= '0;
        dv_den_reg[0]   <= darker_next;
        dv_fg_reg[0]    <= s3_fg_lum_reg;
        dv_bg_reg[0]    <= s3_bg_lum_reg;
        dv_large_reg[0] <= s3_large_reg;
        dv_req_reg[0]   <= s3_req_reg;
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [AW:0] trial;
        logic        fits;

        assign trial = {dv_rem_reg[k], dv_bits_reg[k][QW-1]};
        assign fits  = trial >= {1'b0, dv_den_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[k+1]   <= fits ? AW'(trial - {1'b0, dv_den_reg[k]}) : trial[AW-1:0];
            dv_bits_reg[k+1]  <= dv_bits_reg[k] << 1;
            dv_quo_reg[k+1]   <= {dv_quo_reg[k][QW-2:0], fits};
            dv_den_reg[k+1]   <= dv_den_reg[k];
            dv_fg_reg[k+1]    <= dv_fg_reg[k];
            dv_bg_reg[k+1]    <= dv_bg_reg[k];
            dv_large_reg[k+1] <= dv_large_reg[k];
            dv_req_reg[k+1]   <= dv_req_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // result ports, straight from the last divider stage
    // ------------------------------------------------------------------
    logic [LPW-1:0] fg_pad;
    logic [LPW-1:0] bg_pad;
    logic [QPW-1:0] quo_pad;

    assign fg_pad  = LPW'(dv_fg_reg[QW]);
    assign bg_pad  = LPW'(dv_bg_reg[QW]);
    assign quo_pad = QPW'(dv_quo_reg[QW]);

    assign done              = dv_valid_reg[QW];
    assign fg_luminance      = fg_pad[crchk_pkg::RESULT_W-1:0];
    assign bg_luminance      = bg_pad[crchk_pkg::RESULT_W-1:0];
    assign contrast_ratio    = quo_pad[crchk_pkg::CONTRAST_W-1:0];
    assign large_text        = dv_large_reg[QW];
    assign required_contrast = dv_req_reg[QW];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(accept, LATENCY))
        else $error("result strobe does not match accepted request");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[QW] |-> (dv_rem_reg[QW] < dv_den_reg[QW]))
        else $error("divider remainder not below divisor");

    a_ratio_at_least_one: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[QW] |-> (dv_quo_reg[QW] >= QW'(1) << RFB))
        else $error("contrast ratio below one");

    a_seed_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[0] |-> (dv_rem_reg[0] < dv_den_reg[0]))
        else $error("quotient overflows divider width");

endmodule

// ----- verif/contrast_ratio_checker_core_tb.sv -----
`timescale 1ns / 1ps

module contrast_ratio_checker_core_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 50;
    localparam int ITEMS_PER_SET = 114;

    // own copies of the luminance weights and the 0.05 offset
    localparam logic [63:0] LUMA_RED   = 64'd13933;
    localparam logic [63:0] LUMA_GREEN = 64'd46871;
    localparam logic [63:0] LUMA_BLUE  = 64'd4732;
    localparam logic [63:0] LUMA_BIAS  = 64'd3277;
    localparam logic [crchk_pkg::CHANNEL_W-1:0] FULL_SCALE = 18'd65536;

    typedef struct {
        logic [crchk_pkg::CHANNEL_W-1:0] fg_r;
        logic [crchk_pkg::CHANNEL_W-1:0] fg_g;
        logic [crchk_pkg::CHANNEL_W-1:0] fg_b;
        logic [crchk_pkg::CHANNEL_W-1:0] bg_r;
        logic [crchk_pkg::CHANNEL_W-1:0] bg_g;
        logic [crchk_pkg::CHANNEL_W-1:0] bg_b;
        logic [crchk_pkg::HEIGHT_W-1:0]  height;
        logic                            bold;
    } pair_req_t;

    typedef struct {
        logic [crchk_pkg::RESULT_W-1:0]   fg_lum;
        logic [crchk_pkg::RESULT_W-1:0]   bg_lum;
        logic [crchk_pkg::CONTRAST_W-1:0] ratio;
        logic                             large_flag;
        logic [crchk_pkg::CONTRAST_W-1:0] required;
    } contrast_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [crchk_pkg::CHANNEL_W-1:0] fg_red = '0;
    logic signed [crchk_pkg::CHANNEL_W-1:0] fg_green = '0;
    logic signed [crchk_pkg::CHANNEL_W-1:0] fg_blue = '0;
    logic signed [crchk_pkg::CHANNEL_W-1:0] bg_red = '0;
    logic signed [crchk_pkg::CHANNEL_W-1:0] bg_green = '0;
    logic signed [crchk_pkg::CHANNEL_W-1:0] bg_blue = '0;
    logic [crchk_pkg::HEIGHT_W-1:0] text_height = '0;
    logic is_bold = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [crchk_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [crchk_pkg::CONTRAST_W-1:0] cfg_data = '0;
    logic done;
    logic [crchk_pkg::RESULT_W-1:0] fg_luminance;
    logic [crchk_pkg::RESULT_W-1:0] bg_luminance;
    logic [crchk_pkg::CONTRAST_W-1:0] contrast_ratio;
    logic large_text;
    logic [crchk_pkg::CONTRAST_W-1:0] required_contrast;

    // shadow of the threshold registers
    logic [crchk_pkg::HEIGHT_W-1:0]   thr_height;
    logic [crchk_pkg::HEIGHT_W-1:0]   thr_bold_height;
    logic [crchk_pkg::CONTRAST_W-1:0] thr_large_contrast;
    logic [crchk_pkg::CONTRAST_W-1:0] thr_normal_contrast;

    pair_req_t     pending_pairs[$];
    contrast_res_t expected_results[$];

    int  mismatch_cnt = 0;
    int  cycle_cnt = 0;
    int  gap_mode = 1;
    int  gap_left = 0;
    bit  req_taken = 1'b0;
    pair_req_t     drv_pair;
    pair_req_t     seen_pair;
    contrast_res_t want;

    contrast_ratio_checker_core uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .fg_red            (fg_red),
        .fg_green          (fg_green),
        .fg_blue           (fg_blue),
        .bg_red            (bg_red),
        .bg_green          (bg_green),
        .bg_blue           (bg_blue),
        .text_height       (text_height),
        .is_bold           (is_bold),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .done              (done),
        .fg_luminance      (fg_luminance),
        .bg_luminance      (bg_luminance),
        .contrast_ratio    (contrast_ratio),
        .large_text        (large_text),
        .required_contrast (required_contrast)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] clamp_channel(logic [crchk_pkg::CHANNEL_W-1:0] c);
        if (c[crchk_pkg::CHANNEL_W-1])
            return 64'd0;
        else if (c > FULL_SCALE)
            return 64'(FULL_SCALE);
        else
            return 64'(c);
    endfunction

    function automatic logic [63:0] luma(logic [crchk_pkg::CHANNEL_W-1:0] r,
                                         logic [crchk_pkg::CHANNEL_W-1:0] g,
                                         logic [crchk_pkg::CHANNEL_W-1:0] b);
        logic [63:0] acc;
        acc = LUMA_RED * clamp_channel(r) + LUMA_GREEN * clamp_channel(g)
            + LUMA_BLUE * clamp_channel(b);
        return acc >> 16;
    endfunction

    function automatic contrast_res_t predict_contrast(pair_req_t p);
        contrast_res_t res;
        logic [63:0] lf;
        logic [63:0] lb;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] quot;
        logic [crchk_pkg::HEIGHT_W-1:0] limit;
        lf = luma(p.fg_r, p.fg_g, p.fg_b);
        lb = luma(p.bg_r, p.bg_g, p.bg_b);
        hi = (lf > lb) ? lf : lb;
        lo = (lf > lb) ? lb : lf;
        quot = ((hi + LUMA_BIAS) << 12) / (lo + LUMA_BIAS);
        limit = p.bold ? thr_bold_height : thr_height;
        res.fg_lum     = lf[crchk_pkg::RESULT_W-1:0];
        res.bg_lum     = lb[crchk_pkg::RESULT_W-1:0];
        res.ratio      = quot[crchk_pkg::CONTRAST_W-1:0];
        res.large_flag = (p.height >= limit);
        res.required   = res.large_flag ? thr_large_contrast : thr_normal_contrast;
        return res;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (gap_mode == 0 || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [crchk_pkg::CHANNEL_W-1:0] rand_channel();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return crchk_pkg::CHANNEL_W'($urandom_range(0, 65536));
        else if (r < 60)
            return crchk_pkg::CHANNEL_W'($urandom_range(0, 400));   // dark, high ratios
        else if (r < 80)
            return crchk_pkg::CHANNEL_W'($urandom);
        else
        begin
            case ($urandom_range(0, 6))
                0: return 18'd0;
                1: return 18'd65536;
                2: return 18'd65535;
                3: return 18'd65537;
                4: return 18'h3FFFF;
                5: return 18'h20000;
                default: return 18'h1FFFF;
            endcase
        end
    endfunction

    function automatic logic [crchk_pkg::HEIGHT_W-1:0] rand_height(logic bold);
        int unsigned r;
        logic [crchk_pkg::HEIGHT_W-1:0] limit;
        r = $urandom_range(0, 99);
        limit = bold ? thr_bold_height : thr_height;
        if (r < 40)
            return crchk_pkg::HEIGHT_W'($urandom);
        else if (r < 85)
            return limit + crchk_pkg::HEIGHT_W'($urandom_range(0, 4)) - 16'd2;
        else
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    endfunction

    task automatic queue_pair(logic [crchk_pkg::CHANNEL_W-1:0] fr,
                              logic [crchk_pkg::CHANNEL_W-1:0] fgr,
                              logic [crchk_pkg::CHANNEL_W-1:0] fb,
                              logic [crchk_pkg::CHANNEL_W-1:0] br,
                              logic [crchk_pkg::CHANNEL_W-1:0] bgr,
                              logic [crchk_pkg::CHANNEL_W-1:0] bb,
                              logic [crchk_pkg::HEIGHT_W-1:0] h, logic bold);
        pair_req_t p;
        p.fg_r = fr;
        p.fg_g = fgr;
        p.fg_b = fb;
        p.bg_r = br;
        p.bg_g = bgr;
        p.bg_b = bb;
        p.height = h;
        p.bold = bold;
        pending_pairs.push_back(p);
    endtask

    task automatic report_mismatch(string what, logic [crchk_pkg::CONTRAST_W-1:0] exp_v,
                                   logic [crchk_pkg::CONTRAST_W-1:0] act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_cnt, what, exp_v, act_v);
    endtask

    task automatic check_field(string what, logic [crchk_pkg::CONTRAST_W-1:0] exp_v,
                               logic [crchk_pkg::CONTRAST_W-1:0] act_v);
        if (exp_v !== act_v)
            report_mismatch(what, exp_v, act_v);
    endtask

    task automatic write_reg(crchk_pkg::cfg_reg_t idx, logic [crchk_pkg::CONTRAST_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            crchk_pkg::REG_LARGE_HEIGHT:      thr_height = data[crchk_pkg::HEIGHT_W-1:0];
            crchk_pkg::REG_LARGE_BOLD_HEIGHT: thr_bold_height = data[crchk_pkg::HEIGHT_W-1:0];
            crchk_pkg::REG_LARGE_CONTRAST:    thr_large_contrast = data;
            crchk_pkg::REG_NORMAL_CONTRAST:   thr_normal_contrast = data;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= crchk_pkg::CONTRAST_W'($urandom);
    endtask

    task automatic program_thresholds(logic [crchk_pkg::CONTRAST_W-1:0] h,
                                      logic [crchk_pkg::CONTRAST_W-1:0] bh,
                                      logic [crchk_pkg::CONTRAST_W-1:0] lc,
                                      logic [crchk_pkg::CONTRAST_W-1:0] nc);
        write_reg(crchk_pkg::REG_NORMAL_CONTRAST, nc);
        write_reg(crchk_pkg::REG_LARGE_HEIGHT, h);
        write_reg(crchk_pkg::REG_LARGE_CONTRAST, lc);
        write_reg(crchk_pkg::REG_LARGE_BOLD_HEIGHT, bh);
    endtask

    task automatic wait_idle();
        while (pending_pairs.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random_set(int mode);
        pair_req_t p;
        gap_mode = mode;
        repeat (ITEMS_PER_SET)
        begin
            p.fg_r = rand_channel();
            p.fg_g = rand_channel();
            p.fg_b = rand_channel();
            if ($urandom_range(0, 9) == 0)
            begin
                // same color on both sides
                p.bg_r = p.fg_r;
                p.bg_g = p.fg_g;
                p.bg_b = p.fg_b;
            end
            else
            begin
                p.bg_r = rand_channel();
                p.bg_g = rand_channel();
                p.bg_b = rand_channel();
            end
            p.bold = 1'($urandom_range(0, 1));
            p.height = rand_height(p.bold);
            pending_pairs.push_back(p);
        end
        wait_idle();
    endtask

    // request driver: presents the next pending pair once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!start || req_taken))
        begin
            if (gap_left != 0 || pending_pairs.size() == 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                start       <= 1'b0;
                fg_red      <= crchk_pkg::CHANNEL_W'($urandom);
                fg_green    <= crchk_pkg::CHANNEL_W'($urandom);
                fg_blue     <= crchk_pkg::CHANNEL_W'($urandom);
                bg_red      <= crchk_pkg::CHANNEL_W'($urandom);
                bg_green    <= crchk_pkg::CHANNEL_W'($urandom);
                bg_blue     <= crchk_pkg::CHANNEL_W'($urandom);
                text_height <= crchk_pkg::HEIGHT_W'($urandom);
                is_bold     <= 1'($urandom_range(0, 1));
            end
            else
            begin
                drv_pair = pending_pairs.pop_front();
                start       <= 1'b1;
                fg_red      <= drv_pair.fg_r;
                fg_green    <= drv_pair.fg_g;
                fg_blue     <= drv_pair.fg_b;
                bg_red      <= drv_pair.bg_r;
                bg_green    <= drv_pair.bg_g;
                bg_blue     <= drv_pair.bg_b;
                text_height <= drv_pair.height;
                is_bold     <= drv_pair.bold;
                gap_left = pick_gap();
            end
        end
    end

    // result monitor and request capture
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                if (done)
                begin
                    if (expected_results.size() == 0)
                        report_mismatch("unexpected result, contrast_ratio", '0,
                                        contrast_ratio);
                    else
                    begin
                        want = expected_results.pop_front();
                        check_field("fg_luminance", want.fg_lum, fg_luminance);
                        check_field("bg_luminance", want.bg_lum, bg_luminance);
                        check_field("contrast_ratio", want.ratio, contrast_ratio);
                        check_field("large_text", crchk_pkg::CONTRAST_W'(want.large_flag),
                                    crchk_pkg::CONTRAST_W'(large_text));
                        check_field("required_contrast", want.required, required_contrast);
                    end
                end
                req_taken = start && !busy;
                if (req_taken)
                begin
                    seen_pair.fg_r = fg_red;
                    seen_pair.fg_g = fg_green;
                    seen_pair.fg_b = fg_blue;
                    seen_pair.bg_r = bg_red;
                    seen_pair.bg_g = bg_green;
                    seen_pair.bg_b = bg_blue;
                    seen_pair.height = text_height;
                    seen_pair.bold = is_bold;
                    expected_results.push_back(predict_contrast(seen_pair));
                end
            end
        end
    end

    initial
    begin
        thr_height          = 16'd384;
        thr_bold_height     = 16'd299;
        thr_large_contrast  = 17'd12288;
        thr_normal_contrast = 17'd18432;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed pairs against the reset thresholds
        gap_mode = 1;
        queue_pair(0, 0, 0, 65536, 65536, 65536, 16'd0, 1'b0);
        queue_pair(65536, 65536, 65536, 0, 0, 0, 16'hFFFF, 1'b1);
        queue_pair(18'h20000, 18'h20000, 18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
                   16'd384, 1'b0);
        queue_pair(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF,
                   16'd383, 1'b0);
        queue_pair(32768, 32768, 32768, 32768, 32768, 32768, 16'd299, 1'b1);
        queue_pair(65535, 65535, 65535, 65537, 65537, 65537, 16'd298, 1'b1);
        queue_pair(65536, 0, 0, 0, 65536, 0, 16'd384, 1'b1);
        queue_pair(0, 0, 65536, 0, 0, 0, 16'd298, 1'b0);
        queue_pair(1, 1, 1, 0, 0, 0, 16'd300, 1'b1);
        queue_pair(18'h2AAAA, 18'h15555, 18'h0AAAA, 18'h35555, 18'h0FFFF, 18'h10001,
                   16'hAAAA, 1'b0);
        queue_pair(18'h15555, 18'h2AAAA, 18'h35555, 18'h0AAAA, 18'h30000, 18'h00001,
                   16'h5555, 1'b1);
        queue_pair(65536, 65536, 65536, 65536, 65536, 65536, 16'd1, 1'b0);
        queue_pair(0, 65536, 0, 0, 0, 65536, 16'd385, 1'b0);
        queue_pair(3277, 3277, 3277, 0, 0, 0, 16'hFFFE, 1'b1);
        queue_pair(18'h3FFFF, 0, 65536, 65536, 18'h20000, 0, 16'd0, 1'b1);
        queue_pair(100, 200, 300, 60000, 50000, 40000, 16'd1000, 1'b0);
        run_random_set(1);

        // zero height limits: everything is large
        program_thresholds(17'd0, 17'd0, 17'd4096, 17'd86016);
        queue_pair(0, 0, 0, 65536, 65536, 65536, 16'd0, 1'b0);
        queue_pair(0, 0, 0, 65536, 65536, 65536, 16'd0, 1'b1);
        run_random_set(0);

        program_thresholds(17'd65535, 17'd65535, 17'd86016, 17'd4096);
        run_random_set(1);

        // upper bit of height data is dropped; contrasts out of range pass as written
        program_thresholds(17'h1012C, 17'h10180, 17'd0, 17'h1FFFF);
        run_random_set(0);

        program_thresholds(crchk_pkg::CONTRAST_W'($urandom), crchk_pkg::CONTRAST_W'($urandom),
                           crchk_pkg::CONTRAST_W'($urandom), crchk_pkg::CONTRAST_W'($urandom));
        run_random_set(1);

        program_thresholds(crchk_pkg::CONTRAST_W'($urandom_range(0, 2000)),
                           crchk_pkg::CONTRAST_W'($urandom_range(0, 2000)),
                           crchk_pkg::CONTRAST_W'($urandom_range(4096, 86016)),
                           crchk_pkg::CONTRAST_W'($urandom_range(4096, 86016)));
        run_random_set(1);

        program_thresholds(17'd384, 17'd299, 17'd12288, 17'd18432);
        run_random_set(1);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0d results never arrived", expected_results.size());
            mismatch_cnt += expected_results.size();
        end
        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
